### rtl/pzea_pkg.sv
// ----------------------------------------------------------------------------
// pzea_pkg
// Types and constants shared by the Pauli-Z energy argmin block.
// ----------------------------------------------------------------------------
package pzea_pkg;

  localparam int MAX_TERMS_DEF  = 64;
  localparam int MAX_QUBITS_DEF = 64;

  localparam int QUBIT_W  = 64;
  localparam int COEFF_W  = 32;
  localparam int ENERGY_W = 40;
  localparam int COUNT_W  = 31;
  localparam int CFG_W    = 7;
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;

  localparam longint ENERGY_MAX = 64'sd549755813887;
  localparam longint ENERGY_MIN = -64'sd549755813888;

  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_EVAL  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  // register select is byte address bit 2
  localparam logic REG_NUM_QUBITS = 1'b0;
  localparam logic REG_NUM_TERMS  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_SAT,
    ST_UPDATE
  } state_t;

  typedef struct packed {
    logic [1:0]                cmd;
    logic [5:0]                term_index;
    logic [QUBIT_W-1:0]        z_mask;
    logic [QUBIT_W-1:0]        xy_mask;
    logic signed [COEFF_W-1:0] coefficient;
    logic [QUBIT_W-1:0]        sample_bits;
    logic [6:0]                sample_length;
    logic [COUNT_W-1:0]        sample_count;
  } in_item_t;

  typedef struct packed {
    logic                       skipped;
    logic signed [ENERGY_W-1:0] energy;
    logic [QUBIT_W-1:0]         best_bits;
    logic signed [ENERGY_W-1:0] best_energy;
    logic [COUNT_W-1:0]         best_hits;
    logic                       best_seen;
  } out_item_t;

  typedef struct packed {
    logic [QUBIT_W-1:0]        z_mask;
    logic                      diagonal;
    logic signed [COEFF_W-1:0] coefficient;
  } term_t;

endpackage

### rtl/pzea_term_mem.sv
// ----------------------------------------------------------------------------
// pzea_term_mem
// Cost term table: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module pzea_term_mem #(
  parameter int DEPTH  = pzea_pkg::MAX_TERMS_DEF,
  parameter int ADDR_W = 6
) (
  input  logic                  clk,
  input  logic                  wr_en,
  input  logic [ADDR_W-1:0]     wr_addr,
  input  pzea_pkg::term_t       wr_data,
  input  logic                  rd_en,
  input  logic [ADDR_W-1:0]     rd_addr,
  output pzea_pkg::term_t       rd_data
);
  import pzea_pkg::*;

  term_t mem_r [DEPTH];
  term_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/pauli_z_energy_argmin_top.sv
// ----------------------------------------------------------------------------
// pauli_z_energy_argmin_top
// Sums diagonal Pauli-Z cost terms over a sample and tracks the lowest-energy
// sample seen since the last clear.
// ----------------------------------------------------------------------------
// Load, clear and no-op commands leave busy low.
// Evaluate: busy in RUN (nt = terms summed, one table read and parity/add per
// cycle), DRAIN, SAT and UPDATE, then the result strobe; nt 0: SAT, UPDATE; skip: UPDATE.
// The receiver cannot stall: each result is shown for exactly one cycle.
// Reset: config to num_qubits 64 / num_terms 0, best cleared, table untouched.
module pauli_z_energy_argmin_top #(
  parameter int MAX_TERMS  = pzea_pkg::MAX_TERMS_DEF,
  parameter int MAX_QUBITS = pzea_pkg::MAX_QUBITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  pzea_pkg::in_item_t            in_item,
  output logic                          out_valid,
  output pzea_pkg::out_item_t           out_item,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pzea_pkg::PADDR_W-1:0]  paddr,
  input  logic [pzea_pkg::PDATA_W-1:0]  pwdata,
  output logic [pzea_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);
  import pzea_pkg::*;

  localparam int TIDX_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int TCNT_W = $clog2(MAX_TERMS + 1);
  localparam int ACC_W  = (COEFF_W + 1 + TIDX_W > ENERGY_W + 1) ?
                          (COEFF_W + 1 + TIDX_W) : (ENERGY_W + 1);
  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(ENERGY_MAX);
  localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(ENERGY_MIN);

  // configuration
  logic [CFG_W-1:0] num_qubits_r, num_terms_r;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_qubits_r <= CFG_W'(64);
      num_terms_r  <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_NUM_QUBITS: num_qubits_r <= pwdata[CFG_W-1:0];
        REG_NUM_TERMS:  num_terms_r  <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[2])
      REG_NUM_QUBITS: prdata[CFG_W-1:0] = num_qubits_r;
      REG_NUM_TERMS:  prdata[CFG_W-1:0] = num_terms_r;
      default: ;
    endcase
  end

  // qubit mask and effective term count
  logic [CFG_W-1:0]   nq_eff;
  logic [QUBIT_W-1:0] qmask;
  logic [TCNT_W-1:0]  nt_eff;

  always_comb begin
    if (int'(num_qubits_r) > MAX_QUBITS) nq_eff = CFG_W'(MAX_QUBITS);
    else                                  nq_eff = num_qubits_r;
    if (int'(nq_eff) >= QUBIT_W) qmask = '1;
    else                         qmask = (QUBIT_W'(1) << nq_eff) - QUBIT_W'(1);
    if (int'(num_terms_r) > MAX_TERMS) nt_eff = TCNT_W'(MAX_TERMS);
    else                               nt_eff = TCNT_W'(num_terms_r);
  end

  // state
  state_t state_r, state_nxt;

  logic [TCNT_W-1:0]        t_r, nt_r;
  logic [QUBIT_W-1:0]       bits_m_r, bits_r;
  logic [COUNT_W-1:0]       count_r;
  logic                     skip_r, rd_vld_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ENERGY_W-1:0] energy_r;

  logic [QUBIT_W-1:0]         best_bits_r;
  logic signed [ENERGY_W-1:0] best_energy_r;
  logic [COUNT_W-1:0]         best_hits_r;
  logic                       best_valid_r;

  logic      out_valid_r;
  out_item_t out_item_r;

  logic  accept, ev_start, load_we, clear_best, rd_en, skip_in;
  term_t rd_term, wr_term;

  assign skip_in = in_item.sample_length != num_qubits_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start && in_item.cmd == CMD_EVAL) begin
          if (skip_in)             state_nxt = ST_UPDATE;
          else if (nt_eff == '0)   state_nxt = ST_SAT;
          else                     state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (t_r == nt_r - TCNT_W'(1)) state_nxt = ST_DRAIN;
      end
      ST_DRAIN:  state_nxt = ST_SAT;
      ST_SAT:    state_nxt = ST_UPDATE;
      ST_UPDATE: state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    busy       = state_r != ST_IDLE;
    accept     = start && !busy;
    ev_start   = 1'b0;
    load_we    = 1'b0;
    clear_best = 1'b0;
    rd_en      = state_r == ST_RUN;
    if (accept) begin
      unique case (in_item.cmd)
        CMD_LOAD:  load_we    = int'(in_item.term_index) < MAX_TERMS;
        CMD_EVAL:  ev_start   = 1'b1;
        CMD_CLEAR: clear_best = 1'b1;
        default: ;
      endcase
    end
  end

  always_comb begin
    wr_term.z_mask      = in_item.z_mask;
    wr_term.diagonal    = (in_item.xy_mask & qmask) == '0;
    wr_term.coefficient = in_item.coefficient;
  end

  pzea_term_mem #(
    .DEPTH  (MAX_TERMS),
    .ADDR_W (TIDX_W)
  ) u_term_mem (
    .clk     (clk),
    .wr_en   (load_we),
    .wr_addr (TIDX_W'(in_item.term_index)),
    .wr_data (wr_term),
    .rd_en   (rd_en),
    .rd_addr (t_r[TIDX_W-1:0]),
    .rd_data (rd_term)
  );

  // shared parity and add unit
  logic                    odd;
  logic signed [ACC_W-1:0] coef_ext, acc_nxt;
  logic signed [ENERGY_W-1:0] sat_val;

  always_comb begin
    odd      = ^(rd_term.z_mask & bits_m_r);
    coef_ext = ACC_W'(rd_term.coefficient);
    acc_nxt  = odd ? acc_r - coef_ext : acc_r + coef_ext;
    if (acc_r > SAT_HI)      sat_val = ENERGY_W'(SAT_HI);
    else if (acc_r < SAT_LO) sat_val = ENERGY_W'(SAT_LO);
    else                     sat_val = acc_r[ENERGY_W-1:0];
  end

  // best tracking
  logic                       take;
  logic [QUBIT_W-1:0]         best_bits_nxt;
  logic signed [ENERGY_W-1:0] best_energy_nxt;
  logic [COUNT_W-1:0]         best_hits_nxt;
  logic                       best_valid_nxt;

  always_comb begin
    take = !skip_r && (!best_valid_r || energy_r < best_energy_r ||
           (energy_r == best_energy_r && count_r > best_hits_r));
    best_bits_nxt   = take ? bits_r   : best_bits_r;
    best_energy_nxt = take ? energy_r : best_energy_r;
    best_hits_nxt   = take ? count_r  : best_hits_r;
    best_valid_nxt  = take | best_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      rd_vld_r      <= 1'b0;
      out_valid_r   <= 1'b0;
      best_bits_r   <= '0;
      best_energy_r <= '0;
      best_hits_r   <= '0;
      best_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_vld_r    <= rd_en;
      out_valid_r <= state_r == ST_UPDATE;
      if (clear_best) begin
        best_bits_r   <= '0;
        best_energy_r <= '0;
        best_hits_r   <= '0;
        best_valid_r  <= 1'b0;
      end else if (state_r == ST_UPDATE) begin
        best_bits_r   <= best_bits_nxt;
        best_energy_r <= best_energy_nxt;
        best_hits_r   <= best_hits_nxt;
        best_valid_r  <= best_valid_nxt;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (ev_start) begin
      bits_r   <= in_item.sample_bits;
      bits_m_r <= in_item.sample_bits & qmask;
      count_r  <= in_item.sample_count;
      skip_r   <= skip_in;
      nt_r     <= nt_eff;
      t_r      <= '0;
      acc_r    <= '0;
      energy_r <= '0;
    end else begin
      if (state_r == ST_RUN) t_r <= t_r + TCNT_W'(1);
      if (rd_vld_r && rd_term.diagonal) acc_r <= acc_nxt;
      if (state_r == ST_SAT) energy_r <= sat_val;
    end
    if (state_r == ST_UPDATE) begin
      out_item_r.skipped     <= skip_r;
      out_item_r.energy      <= energy_r;
      out_item_r.best_bits   <= best_bits_nxt;
      out_item_r.best_energy <= best_energy_nxt;
      out_item_r.best_hits   <= best_hits_nxt;
      out_item_r.best_seen   <= best_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // checks
  a_strobe_after_update: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == ST_UPDATE))
    else $error("result strobe without update cycle");

  a_skip_zero_energy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_item_r.skipped) |-> (out_item_r.energy == '0))
    else $error("skipped sample reported nonzero energy");

  a_best_seen: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_item_r.skipped) |-> out_item_r.best_seen)
    else $error("accepted sample left no best");

  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> (t_r < nt_r))
    else $error("term walk past term count");

endmodule

### dv/pauli_z_energy_argmin_top_tb.sv
// ----------------------------------------------------------------------------
// pauli_z_energy_argmin_top_tb
// Self-checking bench for the Pauli-Z energy argmin block. It fills the term
// table, then evaluates samples under several qubit and term counts. A local
// scoring model predicts every result, and each result strobe is checked
// field by field against it. Gaps on the command side are random but for one steady phase.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pauli_z_energy_argmin_top_tb;
  import pzea_pkg::*;

  localparam logic [1:0] CMD_NOP = 2'd3;
  localparam logic [PADDR_W-1:0] ADDR_NUM_QUBITS = {REG_NUM_QUBITS, 2'b00};
  localparam logic [PADDR_W-1:0] ADDR_NUM_TERMS  = {REG_NUM_TERMS, 2'b00};
  localparam int SETTLE_CYCLES = MAX_TERMS_DEF + 16;
  localparam int GAP_PCT       = 33;
  localparam int CYCLE_LIMIT   = 500_000;
  localparam int PRINT_CAP     = 40;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_item_t in_item = '0;
  logic out_valid;
  out_item_t out_item;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  pauli_z_energy_argmin_top DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
    .pready(pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // scoring model state
  logic [6:0]                 cfg_qubits = 7'd64;
  logic [6:0]                 cfg_terms = 7'd0;
  logic [QUBIT_W-1:0]         tab_z [MAX_TERMS_DEF];
  logic                       tab_diag [MAX_TERMS_DEF];
  logic signed [COEFF_W-1:0]  tab_coef [MAX_TERMS_DEF];
  logic [QUBIT_W-1:0]         best_bits = '0;
  longint                     best_e = 0;
  logic [COUNT_W-1:0]         best_cnt = '0;
  logic                       best_ok = 1'b0;

  in_item_t   cmd_fifo [$];
  out_item_t  score_q [$];
  out_item_t  scored;
  out_item_t  want;
  logic [QUBIT_W-1:0] bit_pool [4];
  bit         no_gaps = 1'b0;
  int unsigned n_errors = 0, n_checked = 0, n_eval = 0, n_skip = 0;
  int unsigned n_load = 0, n_clear = 0, n_nop = 0, n_cfg = 0;
  int unsigned cycle_cnt = 0;

  task automatic flag_error(input string msg);
    n_errors++;
    if (n_errors <= PRINT_CAP) $display("ERROR @%0t: %s", $time, msg);
  endtask

  function automatic void queue_cmd(input in_item_t it);
    cmd_fifo.insert(cmd_fifo.size(), it);
  endfunction

  function automatic logic [QUBIT_W-1:0] qubit_mask(input logic [6:0] nq);
    if (nq >= 7'd64) return '1;
    return (64'd1 << nq) - 64'd1;
  endfunction

  // Applies one accepted command to the model; returns 1 when a result is due.
  function automatic bit energy_rank_step(input in_item_t it, output out_item_t res);
    logic [QUBIT_W-1:0] qm;
    int unsigned nt;
    longint acc;
    res = '0;
    qm = qubit_mask(cfg_qubits);
    case (it.cmd)
      CMD_LOAD: begin
        tab_z[it.term_index] = it.z_mask;
        tab_diag[it.term_index] = (it.xy_mask & qm) == '0;
        tab_coef[it.term_index] = it.coefficient;
        n_load++;
        return 1'b0;
      end
      CMD_CLEAR: begin
        best_bits = '0;
        best_e = 0;
        best_cnt = '0;
        best_ok = 1'b0;
        n_clear++;
        return 1'b0;
      end
      CMD_EVAL: begin
        n_eval++;
        acc = 0;
        if (it.sample_length != cfg_qubits) begin
          res.skipped = 1'b1;
          n_skip++;
        end else begin
          nt = (cfg_terms > MAX_TERMS_DEF) ? MAX_TERMS_DEF : cfg_terms;
          for (int t = 0; t < nt; t++) begin
            if (tab_diag[t]) begin
              if (^(tab_z[t] & qm & it.sample_bits)) acc -= longint'(tab_coef[t]);
              else acc += longint'(tab_coef[t]);
            end
          end
          if (acc > ENERGY_MAX) acc = ENERGY_MAX;
          if (acc < ENERGY_MIN) acc = ENERGY_MIN;
          if (!best_ok || acc < best_e || (acc == best_e && it.sample_count > best_cnt)) begin
            best_bits = it.sample_bits;
            best_e = acc;
            best_cnt = it.sample_count;
            best_ok = 1'b1;
          end
        end
        res.energy = acc[ENERGY_W-1:0];
        res.best_bits = best_bits;
        res.best_energy = best_e[ENERGY_W-1:0];
        res.best_hits = best_cnt;
        res.best_seen = best_ok;
        return 1'b1;
      end
      default: begin
        n_nop++;
        return 1'b0;
      end
    endcase
  endfunction

  // ---- stimulus builders --------------------------------------------------
  function automatic in_item_t noise_item();
    in_item_t it;
    it.cmd = 2'($urandom);
    it.term_index = 6'($urandom);
    it.z_mask = {$urandom, $urandom};
    it.xy_mask = {$urandom, $urandom};
    it.coefficient = $urandom;
    it.sample_bits = {$urandom, $urandom};
    it.sample_length = 7'($urandom);
    it.sample_count = 31'($urandom);
    return it;
  endfunction

  function automatic in_item_t cmd_item(input logic [1:0] cmd);
    in_item_t it;
    it = noise_item();
    it.cmd = cmd;
    return it;
  endfunction

  function automatic in_item_t eval_item(input logic [QUBIT_W-1:0] bits,
                                         input logic [6:0] len,
                                         input logic [COUNT_W-1:0] cnt);
    in_item_t it;
    it = cmd_item(CMD_EVAL);
    it.sample_bits = bits;
    it.sample_length = len;
    it.sample_count = cnt;
    return it;
  endfunction

  function automatic in_item_t load_item(input logic [5:0] idx,
                                         input logic [QUBIT_W-1:0] z,
                                         input logic [QUBIT_W-1:0] xy,
                                         input logic [COEFF_W-1:0] coef);
    in_item_t it;
    it = cmd_item(CMD_LOAD);
    it.term_index = idx;
    it.z_mask = z;
    it.xy_mask = xy;
    it.coefficient = coef;
    return it;
  endfunction

  // Mostly diagonal terms: no X/Y at all, or X/Y only above the qubit count.
  function automatic in_item_t rand_term(input logic [5:0] idx);
    logic [QUBIT_W-1:0] xy;
    logic [COEFF_W-1:0] coef;
    xy = {$urandom, $urandom};
    case ($urandom_range(3))
      0, 1: xy = '0;
      2: xy = xy & ~qubit_mask(cfg_qubits);
      default: ;
    endcase
    coef = $urandom;
    case ($urandom_range(19))
      0: coef = 32'h7FFF_FFFF;
      1: coef = 32'h8000_0000;
      default: ;
    endcase
    return load_item(idx, {$urandom, $urandom}, xy, coef);
  endfunction

  function automatic in_item_t rand_item();
    in_item_t it;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 68) begin
      it = cmd_item(CMD_EVAL);
      if ($urandom_range(99) < 85) it.sample_length = cfg_qubits;
      else it.sample_length = 7'($urandom_range(64));
      // repeated bitstrings give energy ties
      if ($urandom_range(99) < 20) it.sample_bits = bit_pool[$urandom_range(3)];
      pick = $urandom_range(99);
      if (pick < 30) it.sample_count = 31'($urandom_range(7));
      else if (pick < 35) it.sample_count = '1;
    end else if (pick < 88) begin
      it = rand_term(6'($urandom_range(63)));
    end else if (pick < 95) begin
      it = cmd_item(CMD_CLEAR);
    end else begin
      it = cmd_item(CMD_NOP);
    end
    return it;
  endfunction

  // ---- command driver -----------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        if (energy_rank_step(in_item, scored)) score_q.insert(score_q.size(), scored);
      end
      if (!start || !busy) begin
        if (cmd_fifo.size() != 0 && (no_gaps || $urandom_range(99) >= GAP_PCT)) begin
          start   <= 1'b1;
          in_item <= cmd_fifo.pop_front();
        end else begin
          start   <= 1'b0;
          in_item <= noise_item();
        end
      end
    end
  end

  // ---- result monitor -----------------------------------------------------
  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want_v);
    if (got !== want_v)
      flag_error($sformatf("%s: got %h, want %h", name, got, want_v));
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (score_q.size() == 0) begin
        flag_error("result strobe with no evaluation outstanding");
      end else begin
        want = score_q.pop_front();
        n_checked++;
        check_field("skipped", 64'(out_item.skipped), 64'(want.skipped));
        check_field("energy", 64'(out_item.energy), 64'(want.energy));
        check_field("best_bits", out_item.best_bits, want.best_bits);
        check_field("best_energy", 64'(out_item.best_energy), 64'(want.best_energy));
        check_field("best_hits", 64'(out_item.best_hits), 64'(want.best_hits));
        check_field("best_seen", 64'(out_item.best_seen), 64'(want.best_seen));
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
               score_q.size());
      $display("pauli_z_energy_argmin_top: mismatch");
      $finish;
    end
  end

  // ---- configuration ------------------------------------------------------
  // Write, then read back in a second transfer.
  task automatic program_reg(input logic [PADDR_W-1:0] addr, input logic [6:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= {25'd0, val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == ADDR_NUM_QUBITS) cfg_qubits = val;
    else cfg_terms = val;
    n_cfg++;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[CFG_W-1:0] !== val)
      flag_error($sformatf("readback at %0d: got %h, want %h", addr, prdata, val));
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Hold off until every queued command went in and every result came out.
  task automatic settle();
    while (cmd_fifo.size() != 0 || start || busy || score_q.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input logic [6:0] q, input logic [6:0] t,
                           input int n, input bit steady);
    int pushed;
    in_item_t it;
    settle();
    program_reg(ADDR_NUM_QUBITS, q);
    program_reg(ADDR_NUM_TERMS, t);
    no_gaps = steady;
    pushed = 0;
    while (pushed < n) begin
      it = rand_item();
      queue_cmd(it);
      if (it.cmd != CMD_NOP) pushed++;
    end
  endtask

  initial begin
    for (int i = 0; i < 4; i++) bit_pool[i] = {$urandom, $urandom};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // reset config (64 qubits, no terms): every energy is zero, so the
    // count tie-break alone decides the best
    queue_cmd(eval_item('1, 7'd64, 31'd5));
    queue_cmd(eval_item('0, 7'd64, 31'd3));
    queue_cmd(eval_item(64'h1, 7'd64, '1));
    queue_cmd(eval_item(64'h2, 7'd64, '1));
    queue_cmd(eval_item('1, 7'd63, 31'd9));
    queue_cmd(eval_item('1, 7'd0, 31'd9));
    queue_cmd(cmd_item(CMD_NOP));
    queue_cmd(cmd_item(CMD_CLEAR));
    queue_cmd(eval_item('0, 7'd64, 31'd0));

    // fill the whole table before any term is summed
    queue_cmd(load_item(6'd0, '1, '0, 32'h7FFF_FFFF));
    queue_cmd(load_item(6'd1, 64'h1, '0, 32'h8000_0000));
    queue_cmd(load_item(6'd2, {$urandom, $urandom}, '1, $urandom));
    queue_cmd(load_item(6'd3, 64'h20, 64'h20, 32'h0001_0000));
    queue_cmd(load_item(6'd4, 64'h8000_0000_0000_0000, '0, 32'hFFFF_0000));
    queue_cmd(load_item(6'd5, '0, '0, 32'h0002_8000));
    for (int i = 6; i < MAX_TERMS_DEF; i++) queue_cmd(rand_term(6'(i)));

    run_phase(7'd64, 7'd64, 0, 1'b0);
    queue_cmd(eval_item('0, 7'd64, 31'd1));
    queue_cmd(eval_item('1, 7'd64, 31'd1));
    queue_cmd(eval_item(64'h8000_0000_0000_0001, 7'd64, 31'd2));
    queue_cmd(eval_item(64'h5555_5555_5555_5555, 7'd64, '1));
    queue_cmd(eval_item('1, 7'd0, 31'd1));

    run_phase(7'd64, 7'd64, 70, 1'b1);
    run_phase(7'd1, 7'd1, 70, 1'b0);
    run_phase(7'd1, 7'd64, 70, 1'b0);
    run_phase(7'd0, 7'd100, 70, 1'b0);
    run_phase(7'd127, 7'd64, 70, 1'b0);
    run_phase(7'd33, 7'd17, 70, 1'b0);
    run_phase(7'd64, 7'd0, 70, 1'b0);
    run_phase(7'd8, 7'd64, 70, 1'b0);
    for (int i = 0; i < 3; i++)
      run_phase(7'($urandom_range(1, 64)), 7'($urandom_range(0, 64)), 70, 1'b0);

    settle();
    if (score_q.size() != 0) flag_error("evaluations left without a result");
    $display("ran %0d evaluations (%0d skipped), %0d loads, %0d clears, %0d no-ops",
             n_eval, n_skip, n_load, n_clear, n_nop);
    $display("%0d register writes, qubit counts 0..127, term counts 0..100; %0d results checked",
             n_cfg, n_checked);
    if (n_errors == 0) begin
      $display("pauli_z_energy_argmin_top: match");
    end else begin
      $display("%0d errors", n_errors);
      $display("pauli_z_energy_argmin_top: mismatch");
    end
    $finish;
  end

endmodule
